@@ rtl/esc_pkg.sv @@
// package: constants and helpers for the epoch seconds to calendar unit
`timescale 1ns / 1ps
package esc_pkg;
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned MinsPerHour = 60;
  localparam int unsigned HoursPerDay = 24;
  localparam int unsigned DaysPerWeek = 7;
  localparam int unsigned FirstYear = 1970;
  localparam int unsigned YearBase = 1900;
  localparam int unsigned FirstWeekday = 4;

  // reciprocals: x/15 for x < 2^30, x/3 for x < 2^18, x/1461 and x/7 for x < 2^16
  localparam logic [30:0] Recip15 = 31'd1145324613;
  localparam logic [18:0] Recip3 = 19'd349526;
  localparam logic [16:0] Recip1461 = 17'd91868;
  localparam logic [16:0] Recip7 = 17'd74899;

  // day count rebased to 1968-01-01, the leap year that opens a four-year block
  localparam logic [15:0] DaysTo1970 = 16'd731;
  localparam logic [15:0] DaysPer4Years = 16'd1461;
  localparam logic [7:0]  YearsTo1968 = 8'd68;
  // 2100 is not a leap year: from 2100-03-01 on a missing feb 29 is skipped
  localparam logic [15:0] Day2100Mar1 = 16'd47541;
  localparam logic [7:0]  Year2100 = 8'd200;

  // days before the first of a month, non-leap
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd0: month_start = 9'd0;
      4'd1: month_start = 9'd31;
      4'd2: month_start = 9'd59;
      4'd3: month_start = 9'd90;
      4'd4: month_start = 9'd120;
      4'd5: month_start = 9'd151;
      4'd6: month_start = 9'd181;
      4'd7: month_start = 9'd212;
      4'd8: month_start = 9'd243;
      4'd9: month_start = 9'd273;
      4'd10: month_start = 9'd304;
      4'd11: month_start = 9'd334;
      default: month_start = 9'd365;
    endcase
  endfunction
endpackage

@@ rtl/epoch_seconds_to_calendar_unit.sv @@
// top level: converts epoch seconds to calendar fields
// done is registered alongside the result fields, carried from start by the valid pipeline
// throughput: one word per cycle, busy is never high
// time of day split in three registered stages by constant reciprocals
// date from a four-year block count over three further stages
// reset (rst, synchronous) clears the valid pipeline only
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_unit import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [7:0]  years_since_1900,
  output logic [8:0]  day_of_year,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday
);
  assign busy = 1'b0;

  logic        v1, v2, v3, v4, v5;
  logic [26:0] m1;
  logic [26:0] h2;
  logic [5:0]  s1, s2, s3, s4, s5;
  logic [5:0]  mi2, mi3, mi4, mi5;
  logic [15:0] d3;
  logic [4:0]  hr3, hr4, hr5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v1 <= start; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  // stages 1 and 2: seconds, then minutes
  esc_divmod u_div_min (
    .clk(clk), .num(epoch_seconds), .quo(m1), .rmd(s1)
  );
  esc_divmod u_div_hour (
    .clk(clk), .num({5'd0, m1}), .quo(h2), .rmd(mi2)
  );
  always_ff @(posedge clk) begin
    s2 <= s1;
  end

  // stage 3: hours and day count
  logic [36:0] p24;
  logic [15:0] q24;
  logic [9:0]  lo24;
  always_comb begin
    p24 = 37'(h2[20:3]) * 37'(Recip3);
    q24 = p24[35:20];
    lo24 = {5'd0, q24[4:0]} * 10'd24;
  end
  always_ff @(posedge clk) begin
    d3 <= q24;
    hr3 <= h2[4:0] - lo24[4:0];
    mi3 <= mi2;
    s3 <= s2;
  end

  // stage 4: four-year block and weekday
  logic        adj;
  logic [15:0] dd;
  logic [32:0] p1461;
  logic [15:0] wsum;
  logic [32:0] p7;
  logic [5:0]  lo7;
  logic [15:0] dd4;
  logic [5:0]  quad4;
  logic        adj4;
  logic [2:0]  wd4, wd5;
  always_comb begin
    adj = (d3 >= Day2100Mar1);
    dd = d3 + DaysTo1970 + {15'd0, adj};
    p1461 = 33'(dd) * 33'(Recip1461);
    wsum = d3 + 16'(FirstWeekday);
    p7 = 33'(wsum) * 33'(Recip7);
    lo7 = {3'd0, p7[21:19]} * 6'd7;
  end
  always_ff @(posedge clk) begin
    dd4 <= dd;
    quad4 <= p1461[32:27];
    adj4 <= adj;
    wd4 <= wsum[2:0] - lo7[2:0];
    s4 <= s3; mi4 <= mi3; hr4 <= hr3;
  end

  // stage 5: year within the block and day of year
  logic [15:0] back;
  logic [15:0] rq;
  logic [10:0] r;
  logic [1:0]  yq;
  logic [10:0] ys;
  logic [10:0] ydf_w;
  logic [7:0]  yrs;
  logic        fix;
  logic [7:0]  yrs5;
  logic [8:0]  yday5, ydf5;
  logic        lp5;
  always_comb begin
    back = {10'd0, quad4} * DaysPer4Years;
    rq = dd4 - back;
    r = rq[10:0];
    if (r < 11'd366) begin
      yq = 2'd0; ys = 11'd0;
    end else if (r < 11'd731) begin
      yq = 2'd1; ys = 11'd366;
    end else if (r < 11'd1096) begin
      yq = 2'd2; ys = 11'd731;
    end else begin
      yq = 2'd3; ys = 11'd1096;
    end
    ydf_w = r - ys;
    yrs = YearsTo1968 + {quad4, 2'b00} + {6'd0, yq};
    fix = adj4 && (yrs == Year2100);
  end
  always_ff @(posedge clk) begin
    yrs5 <= yrs;
    ydf5 <= ydf_w[8:0];
    yday5 <= ydf_w[8:0] - {8'd0, fix};
    lp5 <= (yq == 2'd0);
    wd5 <= wd4;
    s5 <= s4; mi5 <= mi4; hr5 <= hr4;
  end

  // stage 6: month and day
  logic [8:0] st;
  logic [8:0] mst;
  logic [3:0] mon;
  logic [8:0] dm;
  always_comb begin
    mon = 4'd0;
    mst = 9'd0;
    st = 9'd0;
    for (int m = 1; m < 12; m++) begin
      st = month_start(4'(m)) + ((lp5 && m >= 2) ? 9'd1 : 9'd0);
      if (ydf5 >= st) begin
        mon = 4'(m);
        mst = st;
      end
    end
    dm = ydf5 - mst;
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v5;
    second_of_minute <= s5;
    minute_of_hour <= mi5;
    hour_of_day <= hr5;
    years_since_1900 <= yrs5;
    month_index <= mon;
    day_of_month <= dm[4:0] + 5'd1;
    day_of_year <= yday5;
    weekday <= wd5;
  end
endmodule

@@ rtl/esc_divmod.sv @@
// divides a value by sixty in one registered stage via reciprocal multiply
`timescale 1ns / 1ps
module esc_divmod import esc_pkg::*; (
  input  logic        clk,
  input  logic [31:0] num,
  output logic [26:0] quo,
  output logic [5:0]  rmd
);
  logic [60:0] prod;
  logic [26:0] q_est;
  logic [11:0] lo_prod;
  assign prod = 61'(num[31:2]) * 61'(Recip15);
  assign q_est = prod[60:34];
  assign lo_prod = {6'd0, q_est[5:0]} * 12'd60;
  always_ff @(posedge clk) begin
    quo <= q_est;
    rmd <= num[5:0] - lo_prod[5:0];
  end
endmodule

@@ rtl/epoch_seconds_to_calendar_unit_chk.sv @@
// checker: port-level properties of the calendar unit, bound to the top level
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_unit_chk (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [5:0] second_of_minute,
  input logic [3:0] month_index,
  input logic [4:0] day_of_month
);
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##6 done) else $error("missing done");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_sec: assert property (@(posedge clk) disable iff (rst)
    done |-> second_of_minute < 6'd60) else $error("bad second");
  a_mon: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_index < 4'd12 && day_of_month != 5'd0)) else $error("bad date");
endmodule

bind epoch_seconds_to_calendar_unit epoch_seconds_to_calendar_unit_chk u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .second_of_minute(second_of_minute), .month_index(month_index),
  .day_of_month(day_of_month)
);
